@@ hdl/rsk_pkg.sv @@
package rsk_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int KEY_W     = 32;
    localparam int TAG_W     = 16;

    typedef enum logic [0:0] {
        KIND_LOAD = 1'b0,
        KIND_EMIT = 1'b1
    } kind_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } state_t;

    typedef struct packed {
        kind_t             kind;
        logic [KEY_W-1:0]  key;
        logic [TAG_W-1:0]  tag;
    } item_t;

    typedef struct packed {
        logic [KEY_W-1:0]  out_key;
        logic [TAG_W-1:0]  out_tag;
        logic              last;
        logic              empty_res;
        logic              overflow;
    } result_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TAG_W-1:0]  tag;
    } rec_t;

    // chain command, same for every cell
    typedef struct packed {
        logic load;
        logic shift;
    } ctl_t;

endpackage

@@ hdl/rsk_cell.sv @@
module rsk_cell
    import rsk_pkg::*;
(
    input  logic clk,
    input  ctl_t ctl,
    input  rec_t new_rec,
    input  logic occ,
    input  logic prev_le,
    input  rec_t prev_rec,
    input  rec_t next_rec,
    output logic le,
    output rec_t rec
);

    rec_t rec_reg;
    rec_t rec_next;

    // this cell's record stays ahead of the new one (ties keep arrival order)
    assign le  = occ && (rec_reg.key <= new_rec.key);
    assign rec = rec_reg;

    always_comb
    begin
        rec_next = rec_reg;
        if (ctl.load)
        begin
            if (!le)
            begin
                rec_next = prev_le ? new_rec : prev_rec;
            end
        end
        else if (ctl.shift)
        begin
            rec_next = next_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

endmodule

@@ hdl/record_sort_by_key.sv @@
// Load word: sorted in place by the cell chain; loads stream one per cycle while idle.
// Emit word: after accept the block enters ST_EMIT, which moves the first record into the
// output register, then one record per cycle while res_ready is high. An emit with no records
// gives one empty_res result directly. No word is accepted while an emit run is in progress.
// rst_n (async, active low) clears the record count, overflow flag and output valid.
module record_sort_by_key
    import rsk_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;
    logic             res_valid_reg, res_valid_next;
    result_t          res_reg, res_next;
    ctl_t             ctl;
    logic             slot_free;
    logic             take;
    rec_t             new_rec;
    rec_t             recs [DEPTH];
    logic             les  [DEPTH];

    assign new_rec.key = item.key;
    assign new_rec.tag = item.tag;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            rsk_cell u_cell
            (
                .clk      (clk),
                .ctl      (ctl),
                .new_rec  (new_rec),
                .occ      (CNT_W'(i) < count_reg),
                .prev_le  ((i == 0) ? 1'b1 : les[(i == 0) ? 0 : i - 1]),
                .prev_rec (recs[(i == 0) ? 0 : i - 1]),
                .next_rec (recs[(i == DEPTH - 1) ? i : i + 1]),
                .le       (les[i]),
                .rec      (recs[i])
            );
        end
    endgenerate

    assign slot_free  = !res_valid_reg || res_ready;
    assign item_ready = (state_reg == ST_IDLE) && ((item.kind == KIND_LOAD) || slot_free);
    assign take       = item_valid && item_ready;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        ctl            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && item.kind == KIND_LOAD)
                begin
                    if (count_reg == CNT_W'(DEPTH))
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        ctl.load   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else if (take && item.kind == KIND_EMIT)
                begin
                    if (count_reg == '0)
                    begin
                        res_next.out_key   = '0;
                        res_next.out_tag   = '0;
                        res_next.last      = 1'b1;
                        res_next.empty_res = 1'b1;
                        res_next.overflow  = dropped_reg;
                        res_valid_next     = 1'b1;
                        dropped_next       = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    ctl.shift          = 1'b1;
                    res_next.out_key   = recs[0].key;
                    res_next.out_tag   = recs[0].tag;
                    res_next.last      = (count_reg == CNT_W'(1));
                    res_next.empty_res = 1'b0;
                    res_next.overflow  = dropped_reg;
                    res_valid_next     = 1'b1;
                    count_next         = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next   = ST_IDLE;
                        dropped_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("record count above depth");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (count_reg != '0))
        else $error("emit run with no records left");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (take && item.kind == KIND_LOAD && count_reg == CNT_W'(DEPTH))
        |=> dropped_reg && count_reg == CNT_W'(DEPTH))
        else $error("load into full store not flagged");

    a_shift_out: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.shift |=> res_valid_reg && !res_reg.empty_res)
        else $error("shifted record not presented");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.shift && count_reg == CNT_W'(1)) |=> (state_reg == ST_IDLE) && !dropped_reg)
        else $error("emit run did not close on last record");

endmodule
